// ----- design/tbls_pkg.sv -----
// Shared types and constants for the timed brake launch sequencer.
package tbls_pkg;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'b0001,
      PH_COUNTDOWN = 4'b0010,
      PH_BRAKING   = 4'b0100,
      PH_COMPLETE  = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      PHC_IDLE      = 2'd0,
      PHC_COUNTDOWN = 2'd1,
      PHC_BRAKING   = 2'd2,
      PHC_COMPLETE  = 2'd3
   } phase_code_type;

   typedef enum logic [1:0] {
      CMD_COAST = 2'd0,
      CMD_HOLD  = 2'd1,
      CMD_BRAKE = 2'd2,
      CMD_RSVD  = 2'd3
   } motor_cmd_type;

   localparam logic [2:0] CSR_SPINUP    = 3'd0;
   localparam logic [2:0] CSR_BRAKE_DLY = 3'd1;
   localparam logic [2:0] CSR_LAND_DLY  = 3'd2;
   localparam logic [2:0] CSR_RELEASE   = 3'd3;
   localparam logic [2:0] CSR_DEBOUNCE  = 3'd4;
   localparam logic [2:0] CSR_COOLDOWN  = 3'd5;

   localparam logic [15:0] SPINUP_RESET   = 16'd3000;
   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [15:0] COOLDOWN_RESET = 16'd300;
   localparam logic signed [31:0] LANDING_MARGIN_MS = 32'sd500;

   function automatic phase_code_type phase_encode(input phase_type ph);
      phase_code_type code;
      case (ph)
         PH_IDLE:      code = PHC_IDLE;
         PH_COUNTDOWN: code = PHC_COUNTDOWN;
         PH_BRAKING:   code = PHC_BRAKING;
         PH_COMPLETE:  code = PHC_COMPLETE;
         default:      code = PHC_IDLE;
      endcase
      return code;
   endfunction

endpackage

// ----- design/timed_brake_launch_sequencer.sv -----
// Top level of the timed brake launch sequencer: tick register, phase logic, result register.
//
// One tick transaction enters per clock cycle, sustained, while the result is not stalled. Its
// result (motor command and phase) is offered from the result register and taken when rsp_stall
// is low. The tick waits in the input register, where the debounce, phase and brake decisions
// are taken against the current state, until the result register can take it, and then waits
// in the result register until taken. The result register lets a new tick be taken while a
// finished result is still stalled. The configuration port is always ready; write it only while
// no tick is in flight. All time arithmetic wraps at 32 bits.
module timed_brake_launch_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_now_ms,
   input  logic               req_button_level,
   input  logic signed [23:0] req_velocity_sample,
   input  logic               req_velocity_valid,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_motor_command,
   output logic [1:0]         rsp_phase,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   logic [15:0]        spinup_ff;
   logic signed [20:0] brake_dly_ff;
   logic signed [20:0] land_dly_ff;
   logic signed [23:0] release_ff;
   logic [15:0]        debounce_ff;
   logic [15:0]        cooldown_ff;

   logic               in_vld_ff;
   logic [31:0]        now_ff;
   logic               button_ff;
   logic signed [23:0] vel_ff;
   logic               vvld_ff;

   logic               out_vld_ff;
   logic [1:0]         cmd_ff;
   logic [1:0]         phc_ff;

   tbls_pkg::phase_type phase_ff, phase_in;
   logic [31:0]        launch_ff, launch_in;
   logic [31:0]        last_pc_ff, last_pc_in;
   logic [31:0]        last_edge_ff, last_edge_in;
   logic               was_pressed_ff;
   logic               brake_on_ff, brake_on_in;
   logic               brake_used_ff, brake_used_in;
   logic signed [23:0] held_vel_ff, held_vel_in;
   logic [1:0]         cmd_in;

   logic               advance;
   logic               pressed;
   logic               edge_det;
   logic [31:0]        edge_gap;
   logic [31:0]        pc_gap;
   logic               allowed;
   logic signed [31:0] since;
   logic signed [31:0] brake_at;
   logic signed [31:0] land_at;
   logic               brake_on_mid;

   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign csr_ready = 1'b1;

   assign rsp_valid         = out_vld_ff;
   assign rsp_motor_command = cmd_ff;
   assign rsp_phase         = phc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spinup_ff    <= tbls_pkg::SPINUP_RESET;
         brake_dly_ff <= '0;
         land_dly_ff  <= '0;
         release_ff   <= '0;
         debounce_ff  <= tbls_pkg::DEBOUNCE_RESET;
         cooldown_ff  <= tbls_pkg::COOLDOWN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tbls_pkg::CSR_SPINUP:    spinup_ff    <= csr_wdata[15:0];
            tbls_pkg::CSR_BRAKE_DLY: brake_dly_ff <= csr_wdata[20:0];
            tbls_pkg::CSR_LAND_DLY:  land_dly_ff  <= csr_wdata[20:0];
            tbls_pkg::CSR_RELEASE:   release_ff   <= csr_wdata;
            tbls_pkg::CSR_DEBOUNCE:  debounce_ff  <= csr_wdata[15:0];
            tbls_pkg::CSR_COOLDOWN:  cooldown_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         now_ff    <= req_now_ms;
         button_ff <= req_button_level;
         vel_ff    <= req_velocity_sample;
         vvld_ff   <= req_velocity_valid;
      end
   end

   always_comb begin
      pressed      = !button_ff;
      edge_gap     = now_ff - last_edge_ff;
      edge_det     = pressed && !was_pressed_ff && (edge_gap >= {16'd0, debounce_ff});
      last_edge_in = edge_det ? now_ff : last_edge_ff;
      pc_gap       = now_ff - last_pc_ff;
      allowed      = (last_pc_ff == 32'd0) || (pc_gap >= {16'd0, cooldown_ff});
      since        = $signed(now_ff - launch_ff);
      brake_at     = 32'(brake_dly_ff);
      land_at      = 32'(land_dly_ff) + tbls_pkg::LANDING_MARGIN_MS;

      phase_in      = phase_ff;
      launch_in     = launch_ff;
      last_pc_in    = last_pc_ff;
      brake_on_in   = brake_on_ff;
      brake_used_in = brake_used_ff;
      brake_on_mid  = brake_on_ff;

      case (phase_ff)
         tbls_pkg::PH_IDLE: begin
            if (edge_det && allowed) begin
               launch_in  = now_ff + {16'd0, spinup_ff};
               phase_in   = tbls_pkg::PH_COUNTDOWN;
               last_pc_in = now_ff;
            end
         end
         tbls_pkg::PH_COUNTDOWN: begin
            if (since >= 32'sd0) begin
               phase_in      = tbls_pkg::PH_BRAKING;
               last_pc_in    = now_ff;
               brake_on_in   = 1'b0;
               brake_used_in = 1'b0;
            end
         end
         tbls_pkg::PH_BRAKING: begin
            if (!brake_on_ff && !brake_used_ff && since >= brake_at) begin
               brake_on_mid  = 1'b1;
               brake_used_in = 1'b1;
            end
            brake_on_in = brake_on_mid && !(held_vel_ff <= release_ff);
            if (since >= land_at) begin
               phase_in   = tbls_pkg::PH_COMPLETE;
               last_pc_in = now_ff;
            end
         end
         tbls_pkg::PH_COMPLETE: begin
            if (edge_det) begin
               phase_in      = tbls_pkg::PH_IDLE;
               last_pc_in    = now_ff;
               launch_in     = 32'd0;
               brake_on_in   = 1'b0;
               brake_used_in = 1'b0;
            end
         end
         default: ;
      endcase

      held_vel_in = (phase_in == tbls_pkg::PH_BRAKING && vvld_ff) ? vel_ff : held_vel_ff;

      case (phase_in)
         tbls_pkg::PH_COUNTDOWN: cmd_in = tbls_pkg::CMD_HOLD;
         tbls_pkg::PH_BRAKING: begin
            if (brake_on_in) begin
               cmd_in = tbls_pkg::CMD_BRAKE;
            end else if (brake_used_in) begin
               cmd_in = tbls_pkg::CMD_COAST;
            end else begin
               cmd_in = tbls_pkg::CMD_HOLD;
            end
         end
         default: cmd_in = tbls_pkg::CMD_COAST;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= tbls_pkg::PH_IDLE;
         launch_ff      <= '0;
         last_pc_ff     <= '0;
         last_edge_ff   <= '0;
         was_pressed_ff <= 1'b0;
         brake_on_ff    <= 1'b0;
         brake_used_ff  <= 1'b0;
         held_vel_ff    <= '0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         launch_ff      <= launch_in;
         last_pc_ff     <= last_pc_in;
         last_edge_ff   <= last_edge_in;
         was_pressed_ff <= pressed;
         brake_on_ff    <= brake_on_in;
         brake_used_ff  <= brake_used_in;
         held_vel_ff    <= held_vel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff <= cmd_in;
         phc_ff <= tbls_pkg::phase_encode(phase_in);
      end
   end

`ifndef SYNTH
   a_brake_implies_used : assert property (@(posedge clock) disable iff (reset)
      brake_on_ff |-> brake_used_ff)
      else $error("brake applied without being marked used");

   a_brake_cmd_phase : assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && cmd_ff == tbls_pkg::CMD_BRAKE) |-> (phc_ff == tbls_pkg::PHC_BRAKING))
      else $error("brake command outside braking phase");

   a_no_rsvd_cmd : assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (cmd_ff != tbls_pkg::CMD_RSVD))
      else $error("reserved motor command emitted");

   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(phase_ff) && $stable(launch_ff) && $stable(brake_on_ff)))
      else $error("sequencer state changed without a tick");

   a_idle_no_brake : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tbls_pkg::PH_IDLE) |-> (!brake_on_ff && !brake_used_ff))
      else $error("brake flags set in idle");
`endif

endmodule
